### hw/rtl/pcap_stream_deframer_macros.svh
// Assertion helpers used by the RTL file pcd_queue.sv.
`ifndef PCAP_STREAM_DEFRAMER_MACROS_SVH
`define PCAP_STREAM_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcd assertion failed");

// Next-cycle implication, disabled while in reset.
`define PCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcd assertion failed");

`endif

### hw/rtl/pcd_pkg.sv
package pcd_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 65535;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;

  localparam logic [39:0] GHDR_LEN = 40'd24;
  localparam logic [40:0] RHDR_LEN = 41'd16;
  localparam logic [4:0]  GHDR_LAST = 5'd23;
  localparam logic [3:0]  RHDR_LAST = 4'd15;
  localparam logic [4:0]  MAGIC_IDX = 5'd3;
  localparam logic [4:0]  LINK_IDX = 5'd20;

  localparam logic [31:0] MAGIC_US_LE = 32'hA1B2C3D4;
  localparam logic [31:0] MAGIC_US_BE = 32'hD4C3B2A1;
  localparam logic [31:0] MAGIC_NS_LE = 32'hA1B23C4D;
  localparam logic [31:0] MAGIC_NS_BE = 32'h4D3CB2A1;

  localparam logic [19:0] US_PER_SEC = 20'd1000000;
  // ceil(2^38 / 1000): exact quotient by 1000 for any 32-bit value
  localparam logic [28:0] DIV1000_MUL = 29'd274877907;
  localparam int unsigned DIV1000_SHIFT = 38;

  localparam logic [16:0] BATCH_ZERO_LIMIT = 17'h10000;

  typedef enum logic [1:0] {
    KIND_FILE_HDR = 2'd0,
    KIND_META     = 2'd1,
    KIND_PAYLOAD  = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_TOO_SMALL = 2'd0,
    ERR_BAD_MAGIC = 2'd1,
    ERR_BAD_LEN   = 2'd2,
    ERR_TRUNC     = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    PH_GHDR    = 2'd0,
    PH_RHDR    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HALT    = 2'd3
  } phase_t;

  typedef enum logic {
    CFG_FILE_LENGTH   = 1'b0,
    CFG_BATCH_PACKETS = 1'b1
  } cfg_idx_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] frame_index;
    logic [31:0] batch_offset;
    logic [15:0] captured_length;
    logic [31:0] wire_length;
    logic [31:0] ts_sec;
    logic [31:0] ts_sub;
    logic        ts_nano;
    logic [7:0]  payload_byte;
    logic        packet_end;
    logic        batch_end;
    logic [1:0]  header_format;
    logic [31:0] link_type;
    logic [1:0]  error_code;
  } cmd_t;

  function automatic logic [31:0] pcd_word(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic be);
    logic [31:0] w;
    if (be) begin
      w = {b0, b1, b2, b3};
    end else begin
      w = {b3, b2, b1, b0};
    end
    return w;
  endfunction

endpackage

### hw/rtl/pcap_stream_deframer.sv
// The result of an accepted byte is written into the queue at the accept edge, then passes the
// multiply stage and the add stage before it reaches the out_ ports. Throughput: one byte per
// cycle sustained while full is low; the 4-entry queue and the output register absorb short
// stalls on the result side, and full rises when the queue is full.
// Reset (synchronous, rst_n low): parser back to the global header, counters cleared,
// queue and pipe emptied, file_length = 0, batch_packets = 1024. No clearing pass.
module pcap_stream_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [39:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_file_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [31:0] out_frame_index,
  output logic [31:0] out_batch_offset,
  output logic [15:0] out_captured_length,
  output logic [31:0] out_wire_length,
  output logic [51:0] out_time_us,
  output logic [7:0]  out_payload_byte,
  output logic        out_packet_end,
  output logic        out_batch_end,
  output logic [1:0]  out_header_format,
  output logic [31:0] out_link_type,
  output logic [1:0]  out_error_code
);

  pcd_pkg::cmd_t f_cmd, q_data, res;
  logic          f_vld, q_empty, q_full, q_rd, acc;
  logic [51:0]   res_time;

  // take a byte whenever the queue has a free slot
  assign full = q_full;
  assign acc  = push && !q_full;

  // front: parse and classify each byte
  pcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .file_byte (in_file_byte),
    .cmd_vld   (f_vld),
    .cmd       (f_cmd)
  );

  // decouple the parser from output stalls
  pcd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (f_vld),
    .wdata   (f_cmd),
    .rd      (q_rd),
    .rdata   (q_data),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  // back: timestamp conversion and the output register
  pcd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .res      (res),
    .res_time (res_time)
  );

  assign out_kind            = res.kind;
  assign out_frame_index     = res.frame_index;
  assign out_batch_offset    = res.batch_offset;
  assign out_captured_length = res.captured_length;
  assign out_wire_length     = res.wire_length;
  assign out_time_us         = res_time;
  assign out_payload_byte    = res.payload_byte;
  assign out_packet_end      = res.packet_end;
  assign out_batch_end       = res.batch_end;
  assign out_header_format   = res.header_format;
  assign out_link_type       = res.link_type;
  assign out_error_code      = res.error_code;

endmodule

### hw/rtl/pcd_front.sv
module pcd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [39:0]       cfg_wdata,
  input  logic              acc,
  input  logic [7:0]        file_byte,
  output logic              cmd_vld,
  output pcd_pkg::cmd_t     cmd
);

  logic [39:0] flen_r;
  logic [15:0] bpk_r;
  pcd_pkg::phase_t phase_r, phase_nxt;
  logic [39:0] pos_r, pos_nxt;
  logic [7:0]  hdr_r [16];
  logic [7:0]  hdr_nxt [16];
  logic [4:0]  fi_r, fi_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] pkt_r, pkt_nxt;
  logic [15:0] bcnt_r, bcnt_nxt;
  logic [31:0] bbytes_r, bbytes_nxt;
  logic        be_r, be_nxt;
  logic        ns_r, ns_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_r <= '0;
      bpk_r  <= 16'd1024;
    end else if (cfg_we) begin
      case (pcd_pkg::cfg_idx_t'(cfg_index))
        pcd_pkg::CFG_FILE_LENGTH:   flen_r <= cfg_wdata;
        pcd_pkg::CFG_BATCH_PACKETS: bpk_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pcd_pkg::PH_GHDR;
      pos_r    <= '0;
      fi_r     <= '0;
      rem_r    <= '0;
      pkt_r    <= '0;
      bcnt_r   <= '0;
      bbytes_r <= '0;
      be_r     <= 1'b0;
      ns_r     <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      fi_r     <= fi_nxt;
      rem_r    <= rem_nxt;
      pkt_r    <= pkt_nxt;
      bcnt_r   <= bcnt_nxt;
      bbytes_r <= bbytes_nxt;
      be_r     <= be_nxt;
      ns_r     <= ns_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

  logic [31:0] magic, w_sec, w_sub, w_incl, w_orig, w_link;
  logic [3:0]  rk;
  logic [40:0] end_pos, fit_pos;
  logic [16:0] cnt1, limit;
  logic [39:0] pos_inc;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    fi_nxt     = fi_r;
    rem_nxt    = rem_r;
    pkt_nxt    = pkt_r;
    bcnt_nxt   = bcnt_r;
    bbytes_nxt = bbytes_r;
    be_nxt     = be_r;
    ns_nxt     = ns_r;
    hdr_nxt    = hdr_r;
    cmd_vld    = 1'b0;
    cmd        = '0;
    rk         = fi_r[3:0];
    pos_inc    = pos_r + 40'd1;
    magic      = '0;
    w_sec      = '0;
    w_sub      = '0;
    w_incl     = '0;
    w_orig     = '0;
    w_link     = '0;
    end_pos    = '0;
    fit_pos    = '0;
    cnt1       = '0;
    limit      = '0;
    if (acc) begin
      case (phase_r)
        pcd_pkg::PH_GHDR: begin
          if (fi_r == '0 && flen_r < pcd_pkg::GHDR_LEN) begin
            cmd_vld        = 1'b1;
            cmd.kind       = pcd_pkg::KIND_ERROR;
            cmd.error_code = pcd_pkg::ERR_TOO_SMALL;
            phase_nxt      = pcd_pkg::PH_HALT;
          end else begin
            // keep only the magic and the link type bytes
            if (fi_r < 5'd4) begin
              hdr_nxt[fi_r[3:0]] = file_byte;
            end else if (fi_r >= pcd_pkg::LINK_IDX) begin
              hdr_nxt[4'(fi_r - 5'd16)] = file_byte;
            end
            magic = {hdr_nxt[3], hdr_nxt[2], hdr_nxt[1], hdr_nxt[0]};
            w_link = pcd_pkg::pcd_word(hdr_nxt[4], hdr_nxt[5], hdr_nxt[6], hdr_nxt[7], be_r);
            if (fi_r == pcd_pkg::MAGIC_IDX && magic != pcd_pkg::MAGIC_US_LE &&
                magic != pcd_pkg::MAGIC_US_BE && magic != pcd_pkg::MAGIC_NS_LE &&
                magic != pcd_pkg::MAGIC_NS_BE) begin
              cmd_vld        = 1'b1;
              cmd.kind       = pcd_pkg::KIND_ERROR;
              cmd.error_code = pcd_pkg::ERR_BAD_MAGIC;
              phase_nxt      = pcd_pkg::PH_HALT;
            end else begin
              if (fi_r == pcd_pkg::MAGIC_IDX) begin
                be_nxt = (magic == pcd_pkg::MAGIC_US_BE) || (magic == pcd_pkg::MAGIC_NS_BE);
                ns_nxt = (magic == pcd_pkg::MAGIC_NS_LE) || (magic == pcd_pkg::MAGIC_NS_BE);
              end
              pos_nxt = pos_inc;
              if (fi_r == pcd_pkg::GHDR_LAST) begin
                cmd_vld           = 1'b1;
                cmd.kind          = pcd_pkg::KIND_FILE_HDR;
                cmd.header_format = {ns_r, be_r};
                cmd.link_type     = w_link;
                fi_nxt            = '0;
                phase_nxt         = pcd_pkg::PH_RHDR;
              end else begin
                fi_nxt = fi_r + 5'd1;
              end
            end
          end
        end
        pcd_pkg::PH_RHDR: begin
          if (rk == '0 && ({1'b0, pos_r} + pcd_pkg::RHDR_LEN) > {1'b0, flen_r}) begin
            phase_nxt = pcd_pkg::PH_HALT;
          end else begin
            hdr_nxt[rk] = file_byte;
            pos_nxt     = pos_inc;
            if (rk != pcd_pkg::RHDR_LAST) begin
              fi_nxt = {1'b0, rk + 4'd1};
            end else begin
              w_sec  = pcd_pkg::pcd_word(hdr_nxt[0], hdr_nxt[1], hdr_nxt[2], hdr_nxt[3], be_r);
              w_sub  = pcd_pkg::pcd_word(hdr_nxt[4], hdr_nxt[5], hdr_nxt[6], hdr_nxt[7], be_r);
              w_incl = pcd_pkg::pcd_word(hdr_nxt[8], hdr_nxt[9], hdr_nxt[10], hdr_nxt[11], be_r);
              w_orig = pcd_pkg::pcd_word(hdr_nxt[12], hdr_nxt[13], hdr_nxt[14], hdr_nxt[15],
                                         be_r);
              end_pos = {1'b0, pos_r} + 41'd1 + {25'd0, w_incl[15:0]};
              cmd_vld = 1'b1;
              if (w_incl == '0 || w_incl > 32'(pcd_pkg::MAX_PACKET_BYTES)) begin
                cmd.kind       = pcd_pkg::KIND_ERROR;
                cmd.error_code = pcd_pkg::ERR_BAD_LEN;
                phase_nxt      = pcd_pkg::PH_HALT;
              end else if (end_pos > {1'b0, flen_r}) begin
                cmd.kind       = pcd_pkg::KIND_ERROR;
                cmd.error_code = pcd_pkg::ERR_TRUNC;
                phase_nxt      = pcd_pkg::PH_HALT;
              end else begin
                cmd.kind            = pcd_pkg::KIND_META;
                cmd.frame_index     = pkt_r;
                cmd.batch_offset    = bbytes_r;
                cmd.captured_length = w_incl[15:0];
                cmd.wire_length     = w_orig;
                cmd.ts_sec          = w_sec;
                cmd.ts_sub          = w_sub;
                cmd.ts_nano         = ns_r;
                rem_nxt             = w_incl[15:0];
                fi_nxt              = '0;
                phase_nxt           = pcd_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        pcd_pkg::PH_PAYLOAD: begin
          pos_nxt          = pos_inc;
          cmd_vld          = 1'b1;
          cmd.kind         = pcd_pkg::KIND_PAYLOAD;
          cmd.payload_byte = file_byte;
          rem_nxt          = rem_r - {15'd0, (rem_r != '0)};
          bbytes_nxt       = bbytes_r + 32'd1;
          if (rem_nxt == '0) begin
            fit_pos  = {1'b0, pos_inc} + pcd_pkg::RHDR_LEN;
            cnt1     = {1'b0, bcnt_r} + 17'd1;
            limit    = (bpk_r == '0) ? pcd_pkg::BATCH_ZERO_LIMIT : {1'b0, bpk_r};
            cmd.packet_end = 1'b1;
            pkt_nxt  = pkt_r + 32'd1;
            if (cnt1 >= limit || fit_pos > {1'b0, flen_r}) begin
              cmd.batch_end = 1'b1;
              bcnt_nxt      = '0;
              bbytes_nxt    = '0;
            end else begin
              bcnt_nxt = cnt1[15:0];
            end
            fi_nxt    = '0;
            phase_nxt = pcd_pkg::PH_RHDR;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/pcd_queue.sv
`include "pcap_stream_deframer_macros.svh"

module pcd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  pcd_pkg::cmd_t wdata,
  input  logic          rd,
  output pcd_pkg::cmd_t rdata,
  output logic          q_empty,
  output logic          q_full
);

  pcd_pkg::cmd_t mem [pcd_pkg::QDEPTH];
  logic [pcd_pkg::QAW-1:0] wp_r, rp_r;
  logic [pcd_pkg::QAW:0]   cnt_r;

  assign q_empty = (cnt_r == '0);
  assign q_full  = (cnt_r == (pcd_pkg::QAW+1)'(pcd_pkg::QDEPTH));
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (pcd_pkg::QAW+1)'(wr) - (pcd_pkg::QAW+1)'(rd);
    end
  end

  `PCD_ASSERT_NOW(a_no_overflow, q_full, !wr)
  `PCD_ASSERT_NOW(a_no_underflow, q_empty, !rd)
  `PCD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= (pcd_pkg::QAW+1)'(pcd_pkg::QDEPTH))
  `PCD_ASSERT_NEXT(a_cnt_track, wr && !rd, cnt_r == $past(cnt_r) + 1'b1)

endmodule

### hw/rtl/pcd_back.sv
module pcd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  pcd_pkg::cmd_t q_data,
  output logic          q_rd,
  output logic          empty,
  input  logic          pop,
  output pcd_pkg::cmd_t res,
  output logic [51:0]   res_time
);

  logic          a_vld_r, b_vld_r, adv;
  pcd_pkg::cmd_t a_cmd_r, b_cmd_r;
  logic [51:0]   a_prod_r, b_time_r;
  logic [31:0]   a_frac_r;
  logic [51:0]   prod;
  logic [60:0]   div_prod;
  logic [31:0]   frac;

  // advance the whole pipe whenever the output slot frees up
  assign adv   = !b_vld_r || pop;
  assign q_rd  = adv && !q_empty;
  assign empty = !b_vld_r;
  assign res   = b_cmd_r;
  assign res_time = b_time_r;

  assign prod     = 52'(q_data.ts_sec) * 52'(pcd_pkg::US_PER_SEC);
  assign div_prod = 61'(q_data.ts_sub) * 61'(pcd_pkg::DIV1000_MUL);
  assign frac     = q_data.ts_nano ? 32'(div_prod >> pcd_pkg::DIV1000_SHIFT) : q_data.ts_sub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= !q_empty;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd_r  <= q_data;
      a_prod_r <= prod;
      a_frac_r <= frac;
      b_cmd_r  <= a_cmd_r;
      b_time_r <= a_prod_r + 52'(a_frac_r);
    end
  end

endmodule
